### rtl/cwi_pkg.sv
// ----------------------------------------------------------------------------
// cwi_pkg
// Shared types and constants for the climate window indicator.
// ----------------------------------------------------------------------------
`default_nettype none

package cwi_pkg;

	typedef enum logic [1:0] {
		COL_GREEN = 2'd0,
		COL_BLUE  = 2'd1,
		COL_RED   = 2'd2
	} colour_t;

	typedef enum logic [1:0] {
		ST_WITHIN = 2'd0,
		ST_HIGH   = 2'd1,
		ST_LOW    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_MINT = 3'd1,
		M_MAXT = 3'd2,
		M_MINH = 3'd3,
		M_MAXH = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		R_COLOUR_HOLD   = 3'd0,
		R_PRESS_HOLDOFF = 3'd1,
		R_TEMP_FLOOR    = 3'd2,
		R_TEMP_CEILING  = 3'd3,
		R_HUMID_FLOOR   = 3'd4,
		R_HUMID_CEILING = 3'd5
	} reg_idx_t;

	localparam int unsigned IDX_W  = 3;
	localparam int unsigned WDATA_W = 16;
	localparam int unsigned IN_W   = 64;
	localparam int unsigned OUT_W  = 48;

	localparam logic [15:0] RST_COLOUR_HOLD   = 16'd500;
	localparam logic [15:0] RST_PRESS_HOLDOFF = 16'd500;
	localparam logic [7:0]  RST_TEMP_FLOOR    = 8'd5;
	localparam logic [7:0]  RST_TEMP_CEILING  = 8'd30;
	localparam logic [6:0]  RST_HUMID_FLOOR   = 7'd0;
	localparam logic [6:0]  RST_HUMID_CEILING = 7'd100;
	localparam logic [7:0]  RST_MIN_TEMP      = 8'd15;
	localparam logic [7:0]  RST_MAX_TEMP      = 8'd22;
	localparam logic [6:0]  RST_MIN_HUMID     = 7'd30;
	localparam logic [6:0]  RST_MAX_HUMID     = 7'd80;

	typedef struct packed {
		logic [15:0] colour_hold;
		logic [15:0] press_holdoff;
		logic [7:0]  temp_floor;
		logic [7:0]  temp_ceiling;
		logic [6:0]  humid_floor;
		logic [6:0]  humid_ceiling;
	} cfg_t;

	// temperature limits are two's complement
	typedef struct packed {
		logic [7:0] min_t;
		logic [7:0] max_t;
		logic [6:0] min_h;
		logic [6:0] max_h;
	} limits_t;

	typedef struct packed {
		logic [15:0] knob;
		logic        button;
		logic [6:0]  humid;
		logic [7:0]  temp;
		logic [31:0] now;
	} item_t;

	typedef struct packed {
		logic [6:0] max_h;
		logic [6:0] min_h;
		logic [7:0] max_t;
		logic [7:0] min_t;
		logic [7:0] load_value;
		logic       load;
		mode_t      mode;
		status_t    humid_status;
		status_t    temp_status;
		colour_t    colour;
	} result_t;

	function automatic logic elapsed(input logic [31:0] now, input logic [31:0] since,
			input logic [15:0] need);
		logic [31:0] diff;
		diff = now - since;
		return diff >= {16'd0, need};
	endfunction

endpackage

`default_nettype wire

### rtl/cwi_colour.sv
// ----------------------------------------------------------------------------
// cwi_colour
// Indicator colour with minimum hold time, plus window statuses.
// ----------------------------------------------------------------------------
`default_nettype none

module cwi_colour (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic [15:0]     colour_hold,
	input  wire cwi_pkg::item_t  item,
	input  wire cwi_pkg::limits_t lim,
	output cwi_pkg::colour_t     colour_nxt,
	output cwi_pkg::status_t     temp_status,
	output cwi_pkg::status_t     humid_status
);

	cwi_pkg::colour_t colour_q;
	logic [31:0]      changed_at_q;
	cwi_pkg::colour_t want;
	logic             h_bad, t_bad, t_hi, t_lo, h_hi, h_lo;

	always_comb begin
		t_hi  = $signed(item.temp) > $signed(lim.max_t);
		t_lo  = $signed(item.temp) < $signed(lim.min_t);
		h_hi  = item.humid > lim.max_h;
		h_lo  = item.humid < lim.min_h;
		t_bad = t_hi | t_lo;
		h_bad = h_hi | h_lo;

		want = colour_q;
		case (colour_q)
			cwi_pkg::COL_BLUE: begin
				if (!h_bad) want = cwi_pkg::COL_GREEN;
				else if (t_bad) want = cwi_pkg::COL_RED;
			end
			cwi_pkg::COL_RED: begin
				if (!t_bad) want = cwi_pkg::COL_GREEN;
				else if (h_bad) want = cwi_pkg::COL_BLUE;
			end
			default: begin
				if (h_bad) want = cwi_pkg::COL_BLUE;
				else if (t_bad) want = cwi_pkg::COL_RED;
				else want = cwi_pkg::COL_GREEN;
			end
		endcase

		colour_nxt = cwi_pkg::elapsed(item.now, changed_at_q, colour_hold) ? want : colour_q;

		if (t_hi) temp_status = cwi_pkg::ST_HIGH;
		else if (t_lo) temp_status = cwi_pkg::ST_LOW;
		else temp_status = cwi_pkg::ST_WITHIN;

		if (h_hi) humid_status = cwi_pkg::ST_HIGH;
		else if (h_lo) humid_status = cwi_pkg::ST_LOW;
		else humid_status = cwi_pkg::ST_WITHIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q     <= cwi_pkg::COL_GREEN;
			changed_at_q <= '0;
		end else if (adv) begin
			colour_q <= colour_nxt;
			if (colour_nxt != colour_q) changed_at_q <= item.now;
		end
	end

endmodule

`default_nettype wire

### rtl/cwi_editor.sv
// ----------------------------------------------------------------------------
// cwi_editor
// Five-mode limit editor driven by the button and the encoder count.
// ----------------------------------------------------------------------------
`default_nettype none

module cwi_editor (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire cwi_pkg::cfg_t    cfg,
	input  wire cwi_pkg::item_t   item,
	output cwi_pkg::limits_t      lim_q,
	output cwi_pkg::limits_t      lim_nxt,
	output cwi_pkg::mode_t        mode_nxt,
	output logic                  load,
	output logic [7:0]            load_value
);

	typedef struct packed {
		logic [15:0] val;
		logic        load;
	} follow_t;

	cwi_pkg::mode_t mode_q;
	logic [31:0]    press_at_q;
	logic           press_ok;
	follow_t        f;

	// limit takes the count; ceiling check first, then lower bound
	function automatic follow_t follow(input logic [15:0] limit, input logic [15:0] count,
			input logic [15:0] upper, input logic [15:0] lower);
		follow_t r;
		r.val  = limit;
		r.load = 1'b0;
		if (limit != count) begin
			r.val = count;
			if ($signed(count) >= $signed(upper)) begin
				r.val  = upper;
				r.load = 1'b1;
			end else if ($signed(count) <= $signed(lower)) begin
				r.val  = lower;
				r.load = 1'b1;
			end
		end
		return r;
	endfunction

	always_comb begin
		press_ok   = item.button & cwi_pkg::elapsed(item.now, press_at_q, cfg.press_holdoff);
		lim_nxt    = lim_q;
		mode_nxt   = mode_q;
		load       = 1'b0;
		load_value = '0;
		f          = '0;

		if (item.button) begin
			if (press_ok) begin
				load = 1'b1;
				unique case (mode_q)
					cwi_pkg::M_MINT: begin
						mode_nxt   = cwi_pkg::M_MAXT;
						load_value = lim_q.max_t;
					end
					cwi_pkg::M_MAXT: begin
						mode_nxt   = cwi_pkg::M_MINH;
						load_value = {1'b0, lim_q.min_h};
					end
					cwi_pkg::M_MINH: begin
						mode_nxt   = cwi_pkg::M_MAXH;
						load_value = {1'b0, lim_q.max_h};
					end
					default: begin
						mode_nxt   = cwi_pkg::M_MINT;
						load_value = lim_q.min_t;
					end
				endcase
			end
		end else begin
			unique case (mode_q)
				cwi_pkg::M_MINT: begin
					f = follow({{8{lim_q.min_t[7]}}, lim_q.min_t}, item.knob,
						{{8{cfg.temp_ceiling[7]}}, cfg.temp_ceiling},
						{{8{cfg.temp_floor[7]}}, cfg.temp_floor});
					lim_nxt.min_t = f.val[7:0];
				end
				cwi_pkg::M_MAXT: begin
					f = follow({{8{lim_q.max_t[7]}}, lim_q.max_t}, item.knob,
						{{8{cfg.temp_ceiling[7]}}, cfg.temp_ceiling},
						{{8{lim_q.min_t[7]}}, lim_q.min_t});
					lim_nxt.max_t = f.val[7:0];
				end
				cwi_pkg::M_MINH: begin
					f = follow({9'd0, lim_q.min_h}, item.knob,
						{9'd0, cfg.humid_ceiling}, {9'd0, cfg.humid_floor});
					lim_nxt.min_h = f.val[6:0];
				end
				cwi_pkg::M_MAXH: begin
					f = follow({9'd0, lim_q.max_h}, item.knob,
						{9'd0, cfg.humid_ceiling}, {9'd0, lim_q.min_h});
					lim_nxt.max_h = f.val[6:0];
				end
				default: begin
					f = '0;
				end
			endcase
			load       = f.load;
			load_value = f.load ? f.val[7:0] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= cwi_pkg::M_IDLE;
			press_at_q  <= '0;
			lim_q.min_t <= cwi_pkg::RST_MIN_TEMP;
			lim_q.max_t <= cwi_pkg::RST_MAX_TEMP;
			lim_q.min_h <= cwi_pkg::RST_MIN_HUMID;
			lim_q.max_h <= cwi_pkg::RST_MAX_HUMID;
		end else if (adv) begin
			mode_q <= mode_nxt;
			lim_q  <= lim_nxt;
			if (press_ok) press_at_q <= item.now;
		end
	end

endmodule

`default_nettype wire

### rtl/climate_window_indicator.sv
// ----------------------------------------------------------------------------
// climate_window_indicator
// Colour, window statuses and limit editor; one request per cycle unless stalled.
// ----------------------------------------------------------------------------
// Path: input register, combinational state update, result register.
// Throughput: one request per cycle; the state update between the two registers is
//   a single pass, so a new request enters every cycle unless the output stalls.
// Reset: state and config registers take their defaults, colour green, editor idle,
//   limits 15/22/30/80, both channels empty; data registers are not reset.
`default_nettype none

module climate_window_indicator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [cwi_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [cwi_pkg::WDATA_W-1:0] wr_data,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// now_ms[31:0], temp_reading[39:32], humid_reading[46:40], button_level[47],
	// knob_count[63:48]
	input  wire logic [cwi_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// colour[1:0], temp_status[3:2], humid_status[5:4], edit_mode[8:6], knob_load[9],
	// knob_load_value[17:10], low_temp_limit[25:18], high_temp_limit[33:26],
	// low_humid_limit[40:34], high_humid_limit[47:41]
	output logic [cwi_pkg::OUT_W-1:0]        m_axis_tdata
);

	cwi_pkg::cfg_t    cfg_q;
	cwi_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             adv;
	cwi_pkg::result_t res_q;
	logic             out_valid_q;

	cwi_pkg::limits_t lim_cur, lim_nxt;
	cwi_pkg::colour_t colour_nxt;
	cwi_pkg::status_t t_stat, h_stat;
	cwi_pkg::mode_t   mode_nxt;
	logic             load;
	logic [7:0]       load_value;

	assign adv           = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.colour_hold   <= cwi_pkg::RST_COLOUR_HOLD;
			cfg_q.press_holdoff <= cwi_pkg::RST_PRESS_HOLDOFF;
			cfg_q.temp_floor    <= cwi_pkg::RST_TEMP_FLOOR;
			cfg_q.temp_ceiling  <= cwi_pkg::RST_TEMP_CEILING;
			cfg_q.humid_floor   <= cwi_pkg::RST_HUMID_FLOOR;
			cfg_q.humid_ceiling <= cwi_pkg::RST_HUMID_CEILING;
		end else if (wr_en) begin
			unique case (wr_index)
				cwi_pkg::R_COLOUR_HOLD:   cfg_q.colour_hold   <= wr_data;
				cwi_pkg::R_PRESS_HOLDOFF: cfg_q.press_holdoff <= wr_data;
				cwi_pkg::R_TEMP_FLOOR:    cfg_q.temp_floor    <= wr_data[7:0];
				cwi_pkg::R_TEMP_CEILING:  cfg_q.temp_ceiling  <= wr_data[7:0];
				cwi_pkg::R_HUMID_FLOOR:   cfg_q.humid_floor   <= wr_data[6:0];
				cwi_pkg::R_HUMID_CEILING: cfg_q.humid_ceiling <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (adv) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) item_s1 <= s_axis_tdata;
		if (adv) begin
			res_q.colour       <= colour_nxt;
			res_q.temp_status  <= t_stat;
			res_q.humid_status <= h_stat;
			res_q.mode         <= mode_nxt;
			res_q.load         <= load;
			res_q.load_value   <= load_value;
			res_q.min_t        <= lim_nxt.min_t;
			res_q.max_t        <= lim_nxt.max_t;
			res_q.min_h        <= lim_nxt.min_h;
			res_q.max_h        <= lim_nxt.max_h;
		end
	end

	cwi_colour u_colour (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.colour_hold  (cfg_q.colour_hold),
		.item         (item_s1),
		.lim          (lim_cur),
		.colour_nxt   (colour_nxt),
		.temp_status  (t_stat),
		.humid_status (h_stat)
	);

	cwi_editor u_editor (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cfg        (cfg_q),
		.item       (item_s1),
		.lim_q      (lim_cur),
		.lim_nxt    (lim_nxt),
		.mode_nxt   (mode_nxt),
		.load       (load),
		.load_value (load_value)
	);

endmodule

`default_nettype wire

### rtl/cwi_checker.sv
// ----------------------------------------------------------------------------
// cwi_checker
// Port-level checks on the result channel of the climate window indicator.
// ----------------------------------------------------------------------------
`default_nettype none

module cwi_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     m_axis_tvalid,
	input wire logic                     m_axis_tready,
	input wire logic [cwi_pkg::OUT_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_load_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[17:10] == 8'd0)
		else $error("load value without load request");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[3:2] != 2'd3
			&& m_axis_tdata[5:4] != 2'd3 && m_axis_tdata[8:6] <= 3'd4)
		else $error("invalid colour, status or mode code");

	a_idle_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8:6] == 3'd0 |-> !m_axis_tdata[9])
		else $error("load requested while editor idle");

endmodule

bind climate_window_indicator cwi_checker u_cwi_checker (.*);

`default_nettype wire

### sim/tb_climate_window_indicator.sv
// ----------------------------------------------------------------------------
// tb_climate_window_indicator
// Streams sensor readings into the indicator and checks every result against
// an in-bench model of the colour hold, window statuses and limit editor.
// Runs directed readings, flow-control phases, register sweeps (extremes and
// crossed limits) and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_climate_window_indicator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD = 300;
	localparam logic [cwi_pkg::IDX_W-1:0] R_SPARE_LO = 3'd6;
	localparam logic [cwi_pkg::IDX_W-1:0] R_SPARE_HI = 3'd7;

	logic clk;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [cwi_pkg::IDX_W-1:0] wr_index = '0;
	logic [cwi_pkg::WDATA_W-1:0] wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [cwi_pkg::IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [cwi_pkg::OUT_W-1:0] m_axis_tdata;

	// model registers and state, at their reset values
	logic [15:0] hold_ms = 16'd500;
	logic [15:0] holdoff_ms = 16'd500;
	int t_floor = 5;
	int t_ceil = 30;
	int h_floor = 0;
	int h_ceil = 100;
	cwi_pkg::colour_t shown_colour = cwi_pkg::COL_GREEN;
	logic [31:0] colour_since = '0;
	cwi_pkg::mode_t edit_mode = cwi_pkg::M_IDLE;
	logic [31:0] press_since = '0;
	int lim_t_lo = 15;
	int lim_t_hi = 22;
	int lim_h_lo = 30;
	int lim_h_hi = 80;

	cwi_pkg::result_t panels_due[$];
	int unsigned panel_faults = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_taken = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	logic [31:0] stamp = '0;
	int press_run = 0;

	climate_window_indicator dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (holds_taken != holds_asked) begin
			holds_taken <= holds_asked;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : panel_check
		cwi_pkg::result_t seen;
		cwi_pkg::result_t due;
		string bad;
		if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
			seen = cwi_pkg::result_t'(m_axis_tdata);
			if (panels_due.size() == 0) begin
				panel_faults++;
				if (panel_faults <= 10)
					$display("unrequested result %h", seen);
			end else begin
				due = panels_due.pop_front();
				bad = "";
				if (seen.colour !== due.colour) bad = {bad, " colour"};
				if (seen.temp_status !== due.temp_status) bad = {bad, " temp_status"};
				if (seen.humid_status !== due.humid_status) bad = {bad, " humid_status"};
				if (seen.mode !== due.mode) bad = {bad, " edit_mode"};
				if (seen.load !== due.load) bad = {bad, " knob_load"};
				if (seen.load_value !== due.load_value) bad = {bad, " knob_load_value"};
				if (seen.min_t !== due.min_t) bad = {bad, " low_temp_limit"};
				if (seen.max_t !== due.max_t) bad = {bad, " high_temp_limit"};
				if (seen.min_h !== due.min_h) bad = {bad, " low_humid_limit"};
				if (seen.max_h !== due.max_h) bad = {bad, " high_humid_limit"};
				if (bad != "") begin
					panel_faults++;
					if (panel_faults <= 10)
						$display("at %0t:%s wrong: expected %h, got %h", $realtime, bad,
							due, seen);
				end
			end
		end
	end

	function automatic cwi_pkg::status_t window_status(input int v, input int lo, input int hi);
		if (v > hi)
			return cwi_pkg::ST_HIGH;
		if (v < lo)
			return cwi_pkg::ST_LOW;
		return cwi_pkg::ST_WITHIN;
	endfunction

	// the edited limit takes the knob count, pinned to the ceiling first, then the floor
	task automatic track_limit(inout int lim, input int knob, input int ceil_v,
			input int floor_v, output logic pinned);
		pinned = 1'b0;
		if (knob != lim) begin
			lim = knob;
			if (lim >= ceil_v) begin
				lim = ceil_v;
				pinned = 1'b1;
			end else if (lim <= floor_v) begin
				lim = floor_v;
				pinned = 1'b1;
			end
		end
	endtask

	task automatic next_panel(input cwi_pkg::item_t it, output cwi_pkg::result_t r);
		int temp;
		int humid;
		int knob;
		int load_val;
		logic humid_out;
		logic temp_out;
		logic load;
		cwi_pkg::colour_t was;
		cwi_pkg::colour_t goal;
		cwi_pkg::mode_t cur;
		temp = int'($signed(it.temp));
		humid = int'(it.humid);
		knob = int'($signed(it.knob));
		humid_out = humid > lim_h_hi || humid < lim_h_lo;
		temp_out = temp > lim_t_hi || temp < lim_t_lo;
		was = shown_colour;
		goal = was;
		case (was)
			cwi_pkg::COL_BLUE: begin
				if (!humid_out)
					goal = cwi_pkg::COL_GREEN;
				else if (temp_out)
					goal = cwi_pkg::COL_RED;
			end
			cwi_pkg::COL_RED: begin
				if (!temp_out)
					goal = cwi_pkg::COL_GREEN;
				else if (humid_out)
					goal = cwi_pkg::COL_BLUE;
			end
			default: begin
				if (humid_out)
					goal = cwi_pkg::COL_BLUE;
				else if (temp_out)
					goal = cwi_pkg::COL_RED;
			end
		endcase
		if (goal != was && (it.now - colour_since) >= {16'd0, hold_ms}) begin
			shown_colour = goal;
			colour_since = it.now;
		end
		r.temp_status = window_status(temp, lim_t_lo, lim_t_hi);
		r.humid_status = window_status(humid, lim_h_lo, lim_h_hi);

		load = 1'b0;
		load_val = 0;
		cur = edit_mode;
		if (it.button) begin
			if ((it.now - press_since) >= {16'd0, holdoff_ms}) begin
				press_since = it.now;
				load = 1'b1;
				case (cur)
					cwi_pkg::M_MINT: begin
						edit_mode = cwi_pkg::M_MAXT;
						load_val = lim_t_hi;
					end
					cwi_pkg::M_MAXT: begin
						edit_mode = cwi_pkg::M_MINH;
						load_val = lim_h_lo;
					end
					cwi_pkg::M_MINH: begin
						edit_mode = cwi_pkg::M_MAXH;
						load_val = lim_h_hi;
					end
					default: begin
						edit_mode = cwi_pkg::M_MINT;
						load_val = lim_t_lo;
					end
				endcase
			end
		end else begin
			case (cur)
				cwi_pkg::M_MINT: begin
					track_limit(lim_t_lo, knob, t_ceil, t_floor, load);
					load_val = lim_t_lo;
				end
				cwi_pkg::M_MAXT: begin
					track_limit(lim_t_hi, knob, t_ceil, lim_t_lo, load);
					load_val = lim_t_hi;
				end
				cwi_pkg::M_MINH: begin
					track_limit(lim_h_lo, knob, h_ceil, h_floor, load);
					load_val = lim_h_lo;
				end
				cwi_pkg::M_MAXH: begin
					track_limit(lim_h_hi, knob, h_ceil, lim_h_lo, load);
					load_val = lim_h_hi;
				end
				default: ;
			endcase
			if (!load)
				load_val = 0;
		end
		r.colour = shown_colour;
		r.mode = edit_mode;
		r.load = load;
		r.load_value = load_val[7:0];
		r.min_t = lim_t_lo[7:0];
		r.max_t = lim_t_hi[7:0];
		r.min_h = lim_h_lo[6:0];
		r.max_h = lim_h_hi[6:0];
	endtask

	// valid stays high into the next call; callers that pause go through settle
	task automatic send_reading(input cwi_pkg::item_t it);
		cwi_pkg::result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		next_panel(it, r);
		panels_due.push_back(r);
		stamp = it.now;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (panels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cwi_pkg::IDX_W-1:0] idx, input logic [15:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			cwi_pkg::R_COLOUR_HOLD: hold_ms = value;
			cwi_pkg::R_PRESS_HOLDOFF: holdoff_ms = value;
			cwi_pkg::R_TEMP_FLOOR: t_floor = int'($signed(value[7:0]));
			cwi_pkg::R_TEMP_CEILING: t_ceil = int'($signed(value[7:0]));
			cwi_pkg::R_HUMID_FLOOR: h_floor = int'(value[6:0]);
			cwi_pkg::R_HUMID_CEILING: h_ceil = int'(value[6:0]);
			default: ;
		endcase
	endtask

	task automatic set_registers(input logic [15:0] hold, input logic [15:0] holdoff,
			input logic [15:0] tf, input logic [15:0] tc, input logic [15:0] hf,
			input logic [15:0] hc);
		write_reg(cwi_pkg::R_COLOUR_HOLD, hold);
		write_reg(cwi_pkg::R_PRESS_HOLDOFF, holdoff);
		write_reg(cwi_pkg::R_TEMP_FLOOR, tf);
		write_reg(cwi_pkg::R_TEMP_CEILING, tc);
		write_reg(cwi_pkg::R_HUMID_FLOOR, hf);
		write_reg(cwi_pkg::R_HUMID_CEILING, hc);
	endtask

	function automatic cwi_pkg::item_t reading(input logic [31:0] now, input int temp,
			input int humid, input logic button, input int knob);
		cwi_pkg::item_t it;
		it.now = now;
		it.temp = temp[7:0];
		it.humid = humid[6:0];
		it.button = button;
		it.knob = knob[15:0];
		return it;
	endfunction

	// time mostly walks forward around the hold windows; readings and counts
	// cluster on the current limits so edges and clamps get hit
	task automatic send_random_readings(input int unsigned count);
		cwi_pkg::item_t it;
		int pick;
		int span;
		int target;
		repeat (count) begin
			span = (hold_ms > holdoff_ms) ? int'(hold_ms) : int'(holdoff_ms);
			if (span < 4)
				span = 4;
			pick = $urandom_range(99);
			if (pick < 65)
				it.now = stamp + $urandom_range(0, 2 * span);
			else if (pick < 82)
				it.now = stamp + $urandom_range(0, 3);
			else if (pick < 89)
				it.now = colour_since + {16'd0, hold_ms} + $urandom_range(0, 2) - 1;
			else if (pick < 96)
				it.now = press_since + {16'd0, holdoff_ms} + $urandom_range(0, 2) - 1;
			else
				it.now = $urandom;

			pick = $urandom_range(99);
			if (pick < 30)
				it.temp = 8'(lim_t_lo + $urandom_range(0, 4) - 2);
			else if (pick < 60)
				it.temp = 8'(lim_t_hi + $urandom_range(0, 4) - 2);
			else if (pick < 90)
				it.temp = 8'($urandom_range(0, 120) - 40);
			else
				it.temp = 8'($urandom_range(0, 255));

			pick = $urandom_range(99);
			if (pick < 30)
				it.humid = 7'(lim_h_lo + $urandom_range(0, 4) - 2);
			else if (pick < 60)
				it.humid = 7'(lim_h_hi + $urandom_range(0, 4) - 2);
			else if (pick < 90)
				it.humid = 7'($urandom_range(0, 100));
			else
				it.humid = 7'($urandom_range(0, 127));

			if (press_run > 0) begin
				it.button = 1'b1;
				press_run--;
			end else if ($urandom_range(99) < 14) begin
				it.button = 1'b1;
				press_run = $urandom_range(0, 3);
			end else begin
				it.button = 1'b0;
			end

			case (edit_mode)
				cwi_pkg::M_MINT: target = lim_t_lo;
				cwi_pkg::M_MAXT: target = lim_t_hi;
				cwi_pkg::M_MINH: target = lim_h_lo;
				cwi_pkg::M_MAXH: target = lim_h_hi;
				default: target = 0;
			endcase
			pick = $urandom_range(99);
			if (pick < 50)
				it.knob = 16'(target + $urandom_range(0, 6) - 3);
			else if (pick < 65)
				it.knob = 16'(target);
			else if (pick < 85)
				it.knob = 16'($urandom_range(0, 200) - 60);
			else
				it.knob = 16'($urandom_range(0, 65535));
			send_reading(it);
		end
	endtask

	task automatic run_phase(input int unsigned idle, input int unsigned stall,
			input int unsigned count);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		send_random_readings(count);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_reading(reading(32'd1000, 20, 50, 1'b0, 0));
		send_reading(reading(32'd1100, 20, 90, 1'b0, 0));
		// colour still inside its hold time
		send_reading(reading(32'd1200, 100, 50, 1'b0, 0));
		send_reading(reading(32'd1700, 127, 50, 1'b0, 0));
		send_reading(reading(32'd2300, -128, 0, 1'b0, 0));
		send_reading(reading(32'd2900, -128, 127, 1'b0, 0));
		send_reading(reading(32'd3500, 20, 127, 1'b0, 0));
		send_reading(reading(32'd4000, 20, 50, 1'b1, 0));
		// press inside the hold-off: ignored, limit does not follow either
		send_reading(reading(32'd4100, 20, 50, 1'b1, 77));
		send_reading(reading(32'd4200, 20, 50, 1'b0, 18));
		send_reading(reading(32'd4250, 20, 50, 1'b0, 100));
		send_reading(reading(32'd4300, 20, 50, 1'b0, -32768));
		send_reading(reading(32'd4350, 20, 50, 1'b0, 5));
		send_reading(reading(32'd4400, 20, 50, 1'b0, 32767));
		send_reading(reading(32'd4700, 20, 50, 1'b1, 0));
		send_reading(reading(32'd4750, 40, 50, 1'b0, 3));
		send_reading(reading(32'd5300, 40, 50, 1'b1, 0));
		send_reading(reading(32'd5350, 40, 50, 1'b0, -1));
		send_reading(reading(32'd5400, 40, 50, 1'b0, 40));
		send_reading(reading(32'd5900, 40, 50, 1'b1, 0));
		send_reading(reading(32'd5950, 40, 50, 1'b0, 127));
		send_reading(reading(32'd6000, 40, 50, 1'b0, 20));
		send_reading(reading(32'd6500, 40, 50, 1'b1, 0));
		// time wraps past zero
		send_reading(reading(32'hFFFF_FF00, 20, 50, 1'b1, 0));
		send_reading(reading(32'h0000_0100, 20, 90, 1'b0, 0));
		settle();
	endtask

	task automatic test_flow_phases();
		run_phase(0, 0, 250);
		run_phase(87, 0, 250);
		run_phase(0, 87, 250);
		run_phase(18, 18, 250);
		settle();
	endtask

	task automatic test_register_sweep();
		int tf;
		int hf;
		set_registers(16'd0, 16'd0, 16'hFFD8, 16'd80, 16'd0, 16'd100);
		run_phase(18, 18, 100);
		settle();
		// floors above ceilings
		set_registers(16'hFFFF, 16'hFFFF, 16'd80, 16'hFFD8, 16'd100, 16'd0);
		run_phase(0, 0, 100);
		settle();
		// upper bits beyond each register's width must be dropped
		set_registers(16'd1, 16'd2, 16'hAB80, 16'h547F, 16'hFF80, 16'h007F);
		write_reg(R_SPARE_LO, 16'hFFFF);
		write_reg(R_SPARE_HI, 16'h0000);
		run_phase(18, 18, 100);
		repeat (2) begin
			settle();
			tf = $urandom_range(0, 60) - 40;
			hf = $urandom_range(0, 50);
			set_registers(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
				16'(tf), 16'(tf + $urandom_range(0, 60)), 16'(hf),
				16'(hf + $urandom_range(0, 50)));
			run_phase(18, 18, 100);
		end
		settle();
		set_registers(cwi_pkg::RST_COLOUR_HOLD, cwi_pkg::RST_PRESS_HOLDOFF,
			16'(cwi_pkg::RST_TEMP_FLOOR), 16'(cwi_pkg::RST_TEMP_CEILING),
			16'(cwi_pkg::RST_HUMID_FLOOR), 16'(cwi_pkg::RST_HUMID_CEILING));
		run_phase(0, 18, 100);
		settle();
	endtask

	task automatic test_backpressure();
		holds_asked++;
		run_phase(0, 0, 40);
		settle();
		run_phase(0, 0, 15);
		settle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_flow_phases();
		test_register_sweep();
		test_backpressure();
		settle();
		if (panel_faults == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

### climate_window_indicator.f
rtl/cwi_pkg.sv
rtl/cwi_colour.sv
rtl/cwi_editor.sv
rtl/climate_window_indicator.sv
rtl/cwi_checker.sv
sim/tb_climate_window_indicator.sv
